// ----- sv/bis_pkg.sv -----
// Package for the bilinear image scaler: widths, register indexes, defaults.
// No dependencies.
`default_nettype none
package bis_pkg;
	localparam int DefMaxColumns = 256;
	localparam int DefMaxRows    = 256;
	localparam int CoordW = 12;
	localparam int PixW   = 24;
	localparam int StepW  = 21;
	localparam int SizeW  = 9;
	localparam int CfgW   = 21;
	localparam int IdxW   = 3;
	localparam int InW    = 48;
	localparam logic [IdxW-1:0] REG_COLS  = 3'd0;
	localparam logic [IdxW-1:0] REG_ROWS  = 3'd1;
	localparam logic [IdxW-1:0] REG_CSTEP = 3'd2;
	localparam logic [IdxW-1:0] REG_RSTEP = 3'd3;
	localparam logic [IdxW-1:0] REG_MODE  = 3'd4;
	localparam logic [IdxW-1:0] REG_FMT   = 3'd5;
	localparam logic KIND_LOAD  = 1'b0;
	localparam logic KIND_QUERY = 1'b1;

	typedef struct packed {
		logic [SizeW-1:0] cols;
		logic [SizeW-1:0] rows;
		logic [StepW-1:0] cstep;
		logic [StepW-1:0] rstep;
		logic             mode;
		logic             fmt;
	} cfg_t;
endpackage
`default_nettype wire

// ----- sv/bis_axis_map.sv -----
// One axis coordinate mapper: multiply, round or floor, clamp to edge.
// Depends on bis_pkg. One register stage, stall by enable; clamp logic follows it.
`default_nettype none
module bis_axis_map
	import bis_pkg::*;
#(
	parameter int MaxSize = DefMaxColumns,
	localparam int AW = $clog2(MaxSize)
) (
	input  wire logic             clk,
	input  wire logic             en,
	input  wire logic [CoordW-1:0] pos,
	input  wire logic [StepW-1:0] step,
	input  wire logic [SizeW-1:0] size,
	input  wire logic             nearest,
	output logic      [AW-1:0]    lo,
	output logic      [AW-1:0]    hi,
	output logic      [7:0]       frac,
	output logic                  flag
);
	localparam int PW = CoordW + StepW;
	localparam int SW = (AW + 1 > SizeW) ? AW + 1 : SizeW;

	logic [PW-1:0] prod_s1;
	logic [AW:0]   last_s1;
	logic          near_s1;
	logic [SW-1:0] sz;

	always_comb begin
		sz = SW'(size);
		if (sz == '0) sz = SW'(1);
		else if (sz > SW'(MaxSize)) sz = SW'(MaxSize);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			prod_s1 <= PW'(pos) * PW'(step);
			last_s1 <= (AW+1)'(sz - SW'(1));
			near_s1 <= nearest;
		end
	end

	logic [PW:0]   rnd;
	logic [PW-16:0] c;
	logic [7:0]    f;
	logic [AW:0]   n;
	always_comb begin
		rnd = near_s1 ? ({1'b0, prod_s1} + (PW+1)'(32'h8000)) : {1'b0, prod_s1};
		c = rnd[PW:16];
		f = near_s1 ? 8'd0 : prod_s1[15:8];
		flag = 1'b0;
		if (c > (PW-15)'(last_s1)) begin
			c = (PW-15)'(last_s1);
			f = 8'd0;
			flag = 1'b1;
		end
		n = (AW+1)'(c) + (AW+1)'(1);
		if (n > last_s1) begin
			n = last_s1;
			if (f != 8'd0) flag = 1'b1;
		end
		lo = AW'(c);
		hi = AW'(n);
		frac = f;
	end
endmodule
`default_nettype wire

// ----- sv/bis_blend.sv -----
// Bilinear blend of four gray neighbours: one register stage for the row
// products, the final sum is combinational and registered by the caller. Depends on bis_pkg.
`default_nettype none
module bis_blend
	import bis_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       en,
	input  wire logic [7:0] nw,
	input  wire logic [7:0] ne,
	input  wire logic [7:0] sw,
	input  wire logic [7:0] se,
	input  wire logic [7:0] fx,
	input  wire logic [7:0] fy,
	output logic      [7:0] res
);
	logic [16:0] top_s1, bot_s1;
	logic [7:0]  fy_s1;
	logic [8:0]  ifx;
	assign ifx = 9'd256 - 9'(fx);
	always_ff @(posedge clk) begin
		if (en) begin
			top_s1 <= 17'(nw) * 17'(ifx) + 17'(ne) * 17'(fx);
			bot_s1 <= 17'(sw) * 17'(ifx) + 17'(se) * 17'(fx);
			fy_s1  <= fy;
		end
	end
	logic [25:0] sum;
	assign sum = 26'(top_s1) * 26'(9'd256 - 9'(fy_s1)) + 26'(bot_s1) * 26'(fy_s1);
	assign res = sum[23:16];
endmodule
`default_nettype wire

// ----- sv/bilinear_image_scaler.sv -----
// Bilinear image scaler: frame store with nearest and bilinear lookup.
// Fully pipelined; one load or query per cycle when the output is taken.
// A query result passes these registers after acceptance: map multiply, clamp and
// bank address, store read, blend products, blend sum into output register.
// Loads are registered after acceptance and then write the store, in order
// with queries, and give no result. The store is four banks split by column
// and row parity so that the four neighbours are read in the same cycle. When
// m_axis_tvalid is high and m_axis_tready is low the whole pipeline holds and
// s_axis_tready falls; nothing is lost or repeated. Reset clears valid bits
// and sets registers to defaults; the frame store is not cleared and holds
// garbage until loaded. Configuration writes land at once by index.
// s_axis tdata {pixel, row, column}, tuser = kind. m_axis tdata = out_pixel,
// tuser = clamped.
`default_nettype none
module bilinear_image_scaler
	import bis_pkg::*;
#(
	parameter int MAX_COLUMNS = DefMaxColumns,
	parameter int MAX_ROWS    = DefMaxRows
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            s_axis_tvalid,
	output logic                 s_axis_tready,
	input  wire logic [InW-1:0]  s_axis_tdata,  // column[11:0], row[23:12], pixel[47:24]
	input  wire logic            s_axis_tuser,  // kind
	output logic                 m_axis_tvalid,
	input  wire logic            m_axis_tready,
	output logic [PixW-1:0]      m_axis_tdata,  // out_pixel[23:0]
	output logic                 m_axis_tuser,  // clamped
	input  wire logic            cfg_we,
	input  wire logic [IdxW-1:0] cfg_index,
	input  wire logic [CfgW-1:0] cfg_data
);
	localparam int CW  = $clog2(MAX_COLUMNS);
	localparam int RW  = $clog2(MAX_ROWS);
	localparam int BD  = (MAX_COLUMNS / 2 + MAX_COLUMNS % 2) * (MAX_ROWS / 2 + MAX_ROWS % 2);
	localparam int BCOLS = MAX_COLUMNS / 2 + MAX_COLUMNS % 2;
	localparam int BAW = $clog2(BD) > 0 ? $clog2(BD) : 1;

	cfg_t cfg_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '{cols: 9'd256, rows: 9'd256, cstep: 21'd65536,
				rstep: 21'd65536, mode: 1'b1, fmt: 1'b0};
		end else if (cfg_we) begin
			case (cfg_index)
				REG_COLS:  cfg_q.cols  <= cfg_data[SizeW-1:0];
				REG_ROWS:  cfg_q.rows  <= cfg_data[SizeW-1:0];
				REG_CSTEP: cfg_q.cstep <= cfg_data;
				REG_RSTEP: cfg_q.rstep <= cfg_data;
				REG_MODE:  cfg_q.mode  <= cfg_data[0];
				REG_FMT:   cfg_q.fmt   <= cfg_data[0];
				default: ;
			endcase
		end
	end

	logic en;
	assign en = m_axis_tready || !m_axis_tvalid;
	assign s_axis_tready = en;

	logic [CoordW-1:0] in_col, in_row;
	logic [PixW-1:0]   in_pix;
	logic acc, query, load;
	assign in_col = s_axis_tdata[11:0];
	assign in_row = s_axis_tdata[23:12];
	assign in_pix = s_axis_tdata[47:24];
	assign acc   = s_axis_tvalid && en;
	assign query = acc && (s_axis_tuser == KIND_QUERY);
	assign load  = acc && (s_axis_tuser == KIND_LOAD) &&
		({1'b0, in_col} < (CoordW+1)'(MAX_COLUMNS)) &&
		({1'b0, in_row} < (CoordW+1)'(MAX_ROWS));

	logic nearest;
	assign nearest = cfg_q.fmt || !cfg_q.mode;

	// stage 1/2: coordinate mapping
	logic [CW-1:0] c0, c1;
	logic [RW-1:0] r0, r1;
	logic [7:0] fx, fy;
	logic fcx, fcy;
	bis_axis_map #(.MaxSize(MAX_COLUMNS)) u_mapx (.clk, .en, .pos(in_col),
		.step(cfg_q.cstep), .size(cfg_q.cols), .nearest, .lo(c0), .hi(c1),
		.frac(fx), .flag(fcx));
	bis_axis_map #(.MaxSize(MAX_ROWS)) u_mapy (.clk, .en, .pos(in_row),
		.step(cfg_q.rstep), .size(cfg_q.rows), .nearest, .lo(r0), .hi(r1),
		.frac(fy), .flag(fcy));

	logic v_s1, fmt_s1, near_s1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s1 <= 1'b0;
		else if (en) v_s1 <= query;
	end
	always_ff @(posedge clk) begin
		if (en) begin
			fmt_s1 <= cfg_q.fmt;
			near_s1 <= nearest;
		end
	end

	// stage 2: bank addresses; bank = {row parity, column parity}
	logic [CW-1:0] ce, co;
	logic [RW-1:0] re, ro;
	always_comb begin
		ce = c0[0] ? c1 : c0;
		co = c0[0] ? c0 : c1;
		re = r0[0] ? r1 : r0;
		ro = r0[0] ? r0 : r1;
	end
	function automatic logic [BAW-1:0] baddr(input logic [CW-1:0] c, input logic [RW-1:0] r);
		return BAW'(32'(r >> 1) * BCOLS + 32'(c >> 1));
	endfunction

	logic v_s2, fmt_s2, near_s2, flag_s2, cp_s2, rp_s2, ceq_s2, req_s2;
	logic [7:0] fx_s2, fy_s2;
	logic [BAW-1:0] a_s2 [4];
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s2 <= 1'b0;
		else if (en) v_s2 <= v_s1;
	end
	always_ff @(posedge clk) begin
		if (en) begin
			fmt_s2 <= fmt_s1; near_s2 <= near_s1; flag_s2 <= fcx | fcy;
			cp_s2 <= c0[0]; rp_s2 <= r0[0]; fx_s2 <= fx; fy_s2 <= fy;
			ceq_s2 <= (c0 == c1); req_s2 <= (r0 == r1);
			a_s2[0] <= baddr(ce, re);
			a_s2[1] <= baddr(co, re);
			a_s2[2] <= baddr(ce, ro);
			a_s2[3] <= baddr(co, ro);
		end
	end

	// load write one stage behind acceptance, in order with query reads
	logic lw_s1;
	logic [1:0] wb_s1;
	logic [BAW-1:0] wa_s1;
	logic [PixW-1:0] wd_s1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) lw_s1 <= 1'b0;
		else if (en) lw_s1 <= load;
	end
	always_ff @(posedge clk) begin
		if (en) begin
			wb_s1 <= {in_row[0], in_col[0]};
			wa_s1 <= baddr(CW'(in_col), RW'(in_row));
			wd_s1 <= in_pix;
		end
	end

	// stage 3: bank reads
	logic [PixW-1:0] mem0 [BD];
	logic [PixW-1:0] mem1 [BD];
	logic [PixW-1:0] mem2 [BD];
	logic [PixW-1:0] mem3 [BD];
	logic [PixW-1:0] d_s3 [4];
	always_ff @(posedge clk) begin
		if (en && lw_s1 && wb_s1 == 2'd0) mem0[wa_s1] <= wd_s1;
		if (en) d_s3[0] <= mem0[a_s2[0]];
	end
	always_ff @(posedge clk) begin
		if (en && lw_s1 && wb_s1 == 2'd1) mem1[wa_s1] <= wd_s1;
		if (en) d_s3[1] <= mem1[a_s2[1]];
	end
	always_ff @(posedge clk) begin
		if (en && lw_s1 && wb_s1 == 2'd2) mem2[wa_s1] <= wd_s1;
		if (en) d_s3[2] <= mem2[a_s2[2]];
	end
	always_ff @(posedge clk) begin
		if (en && lw_s1 && wb_s1 == 2'd3) mem3[wa_s1] <= wd_s1;
		if (en) d_s3[3] <= mem3[a_s2[3]];
	end

	logic v_s3, fmt_s3, near_s3, flag_s3, cp_s3, rp_s3, ceq_s3, req_s3;
	logic [7:0] fx_s3, fy_s3;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s3 <= 1'b0;
		else if (en) v_s3 <= v_s2;
	end
	always_ff @(posedge clk) begin
		if (en) begin
			fmt_s3 <= fmt_s2; near_s3 <= near_s2; flag_s3 <= flag_s2;
			cp_s3 <= cp_s2; rp_s3 <= rp_s2; fx_s3 <= fx_s2; fy_s3 <= fy_s2;
			ceq_s3 <= ceq_s2; req_s3 <= req_s2;
		end
	end

	// unswizzle banks into neighbours; an edge neighbour repeats the edge pixel
	logic [PixW-1:0] pnw, pne, psw, pse, tw, te, bw, be;
	always_comb begin
		tw = rp_s3 ? d_s3[2] : d_s3[0];
		te = rp_s3 ? d_s3[3] : d_s3[1];
		bw = rp_s3 ? d_s3[0] : d_s3[2];
		be = rp_s3 ? d_s3[1] : d_s3[3];
		if (req_s3) begin
			bw = tw;
			be = te;
		end
		pnw = cp_s3 ? te : tw;
		pne = ceq_s3 ? pnw : (cp_s3 ? tw : te);
		psw = cp_s3 ? be : bw;
		pse = ceq_s3 ? psw : (cp_s3 ? bw : be);
	end

	logic [PixW-1:0] nr_s4;
	logic v_s4, near_s4, flag_s4, v_s5, flag_s5;
	logic [PixW-1:0] nr_s5;
	logic [7:0] blend;
	bis_blend u_blend (.clk, .en, .nw(pnw[7:0]), .ne(pne[7:0]), .sw(psw[7:0]),
		.se(pse[7:0]), .fx(fx_s3), .fy(fy_s3), .res(blend));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else if (en) begin
			v_s4 <= v_s3;
			v_s5 <= v_s4;
		end
	end
	always_ff @(posedge clk) begin
		if (en) begin
			nr_s4 <= fmt_s3 ? pnw : {16'd0, pnw[7:0]};
			near_s4 <= near_s3; flag_s4 <= flag_s3;
			nr_s5 <= near_s4 ? nr_s4 : {16'd0, blend};
			flag_s5 <= flag_s4;
		end
	end
	assign m_axis_tvalid = v_s5;
	assign m_axis_tdata  = nr_s5;
	assign m_axis_tuser  = flag_s5;
endmodule
`default_nettype wire

// ----- sv/bis_checker.sv -----
// Port checker for the bilinear image scaler, bound to the top level.
// Depends on bis_pkg.
`default_nettype none
module bis_checker
	import bis_pkg::*;
(
	input wire logic            clk,
	input wire logic            arst_n,
	input wire logic            s_axis_tvalid,
	input wire logic            s_axis_tready,
	input wire logic            m_axis_tvalid,
	input wire logic            m_axis_tready,
	input wire logic [PixW-1:0] m_axis_tdata,
	input wire logic            m_axis_tuser
);
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
		&& $stable(m_axis_tuser))
		else $error("output dropped during stall");
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!m_axis_tvalid |-> s_axis_tready)
		else $error("input blocked with empty output");
	a_stall: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |-> !s_axis_tready)
		else $error("input taken during stall");
	a_known: assert property (@(posedge clk) disable iff (!arst_n)
		!$isunknown(m_axis_tvalid) && !$isunknown(s_axis_tvalid && s_axis_tready))
		else $error("unknown handshake");
endmodule

bind bilinear_image_scaler bis_checker u_chk (.clk, .arst_n, .s_axis_tvalid,
	.s_axis_tready, .m_axis_tvalid, .m_axis_tready,
	.m_axis_tdata, .m_axis_tuser);
`default_nettype wire

// ----- tb/tb.sv -----
// Self-checking testbench for bilinear_image_scaler: loads and queries on the input
// stream, results predicted per query or given by the directed table and checked in order. Depends on bis_pkg.
`timescale 1ns / 100ps
module tb;
	import bis_pkg::*;

	localparam int StoreCols = DefMaxColumns;
	localparam int StoreRows = DefMaxRows;

	typedef struct packed {
		logic [PixW-1:0] pixel;
		logic            clamped;
	} scaled_t;

	typedef struct packed {
		logic              kind;
		logic [CoordW-1:0] col;
		logic [CoordW-1:0] row;
		logic [PixW-1:0]   pix;
		logic              typed;
		logic [PixW-1:0]   exp_pix;
		logic              exp_clamped;
	} dir_row_t;

	localparam dir_row_t DIR_TAB [18] = '{
		'{KIND_LOAD,  12'd0,    12'd0,    24'hABCD00, 1'b0, 24'h0,  1'b0},
		'{KIND_LOAD,  12'd1,    12'd0,    24'h0000FF, 1'b0, 24'h0,  1'b0},
		'{KIND_LOAD,  12'd0,    12'd1,    24'hFFFF80, 1'b0, 24'h0,  1'b0},
		'{KIND_LOAD,  12'd1,    12'd1,    24'h123440, 1'b0, 24'h0,  1'b0},
		'{KIND_LOAD,  12'd4095, 12'd4095, 24'hFFFFFF, 1'b0, 24'h0,  1'b0},
		'{KIND_LOAD,  12'd256,  12'd0,    24'hFFFFFF, 1'b0, 24'h0,  1'b0},
		'{KIND_LOAD,  12'd0,    12'd256,  24'hFFFFFF, 1'b0, 24'h0,  1'b0},
		'{KIND_QUERY, 12'd0,    12'd0,    24'hFFFFFF, 1'b1, 24'h00, 1'b0},
		'{KIND_QUERY, 12'd1,    12'd0,    24'h000000, 1'b1, 24'hFF, 1'b0},
		'{KIND_QUERY, 12'd0,    12'd1,    24'h000000, 1'b1, 24'h80, 1'b0},
		'{KIND_QUERY, 12'd1,    12'd1,    24'h000000, 1'b1, 24'h40, 1'b0},
		'{KIND_QUERY, 12'd2,    12'd1,    24'h000000, 1'b1, 24'h40, 1'b1},
		'{KIND_QUERY, 12'd4095, 12'd4095, 24'h000000, 1'b1, 24'h40, 1'b1},
		'{KIND_QUERY, 12'd0,    12'd4095, 24'h000000, 1'b1, 24'h80, 1'b1},
		'{KIND_QUERY, 12'd3,    12'd0,    24'h000000, 1'b0, 24'h0,  1'b0},
		'{KIND_LOAD,  12'd0,    12'd0,    24'h000001, 1'b0, 24'h0,  1'b0},
		'{KIND_QUERY, 12'd0,    12'd0,    24'h000000, 1'b1, 24'h01, 1'b0},
		'{KIND_QUERY, 12'd2048, 12'd1,    24'h000000, 1'b0, 24'h0,  1'b0}
	};

	logic            clk;
	logic            arst_n;
	logic            s_axis_tvalid;
	logic            s_axis_tready;
	logic [InW-1:0]  s_axis_tdata;
	logic            s_axis_tuser;
	logic            m_axis_tvalid;
	logic            m_axis_tready;
	logic [PixW-1:0] m_axis_tdata;
	logic            m_axis_tuser;
	logic            cfg_we;
	logic [IdxW-1:0] cfg_index;
	logic [CfgW-1:0] cfg_data;

	logic [PixW-1:0]  src_pixels [StoreCols*StoreRows];
	bit               src_loaded [StoreCols*StoreRows];
	logic [SizeW-1:0] sh_cols;
	logic [SizeW-1:0] sh_rows;
	logic [StepW-1:0] sh_cstep;
	logic [StepW-1:0] sh_rstep;
	logic             sh_mode;
	logic             sh_fmt;

	scaled_t pending_pixels [$];
	int      mismatches = 0;
	int      ready_hold = 0;
	bit      calm;

	bilinear_image_scaler dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.s_axis_tuser (s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tuser (m_axis_tuser),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#20_000_000;
		$display("CHECKS FAILED");
		$finish;
	end

	function automatic int draw_gap();
		if (calm)
			return 0;
		return $urandom_range(0, 15);
	endfunction

	function automatic int clip_size(logic [SizeW-1:0] v, int limit);
		if (v == 0)
			return 1;
		if (v > limit)
			return limit;
		return int'(v);
	endfunction

	function automatic void map_axis(input logic [CoordW-1:0] opos, input logic [StepW-1:0] step,
			input int size, input bit nearest, output int lo, output int hi, output int frac,
			inout bit flag);
		logic [63:0] pos;
		logic [63:0] c;
		int f;
		int last;
		int n;
		pos = 64'(opos) * 64'(step);
		last = size - 1;
		if (nearest) begin
			c = (pos + 64'h8000) >> 16;
			f = 0;
		end else begin
			c = pos >> 16;
			f = int'(pos[15:8]);
		end
		if (c > 64'(last)) begin
			c = 64'(last);
			f = 0;
			flag = 1'b1;
		end
		n = int'(c) + 1;
		if (n > last) begin
			n = last;
			if (f != 0)
				flag = 1'b1;
		end
		lo = int'(c);
		hi = n;
		frac = f;
	endfunction

	function automatic logic [PixW-1:0] src_at(int c, int r);
		return src_pixels[r*StoreCols + c];
	endfunction

	function automatic scaled_t scale_pixel(logic [CoordW-1:0] c, logic [CoordW-1:0] r);
		int c0, c1, r0, r1, fx, fy;
		int top, bottom;
		bit nearest;
		bit flag;
		logic [PixW-1:0] p_nw, p_ne, p_sw, p_se;
		scaled_t res;
		flag = 1'b0;
		nearest = sh_fmt || !sh_mode;
		map_axis(c, sh_cstep, clip_size(sh_cols, StoreCols), nearest, c0, c1, fx, flag);
		map_axis(r, sh_rstep, clip_size(sh_rows, StoreRows), nearest, r0, r1, fy, flag);
		p_nw = src_at(c0, r0);
		if (sh_fmt) begin
			res.pixel = p_nw;
		end else if (nearest) begin
			res.pixel = {16'h0, p_nw[7:0]};
		end else begin
			p_ne = src_at(c1, r0);
			p_sw = src_at(c0, r1);
			p_se = src_at(c1, r1);
			top = int'(p_nw[7:0]) * (256 - fx) + int'(p_ne[7:0]) * fx;
			bottom = int'(p_sw[7:0]) * (256 - fx) + int'(p_se[7:0]) * fx;
			res.pixel = {16'h0, 8'((top * (256 - fy) + bottom * fy) >> 16)};
		end
		res.clamped = flag;
		return res;
	endfunction

	task automatic push(logic kind, logic [CoordW-1:0] c, logic [CoordW-1:0] r,
			logic [PixW-1:0] p, bit typed, logic [PixW-1:0] ep, logic ec);
		int gap;
		scaled_t e;
		gap = draw_gap();
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {p, r, c};
		s_axis_tuser <= kind;
		do @(posedge clk); while (!s_axis_tready);
		if (kind == KIND_LOAD) begin
			if (c < StoreCols && r < StoreRows) begin
				src_pixels[r*StoreCols + c] = p;
				src_loaded[r*StoreCols + c] = 1'b1;
			end
		end else begin
			e.pixel = ep;
			e.clamped = ec;
			pending_pixels.push_back(typed ? e : scale_pixel(c, r));
		end
		@(negedge clk);
	endtask

	task automatic drain();
		s_axis_tvalid <= 1'b0;
		while (pending_pixels.size() != 0)
			@(negedge clk);
		repeat (12) @(negedge clk);
	endtask

	task automatic configure(logic [SizeW-1:0] cols, logic [SizeW-1:0] rows,
			logic [StepW-1:0] cstep, logic [StepW-1:0] rstep, logic mode, logic fmt);
		logic [CfgW-1:0] vals [6];
		logic [IdxW-1:0] idx [6];
		vals = '{CfgW'(cols), CfgW'(rows), CfgW'(cstep), CfgW'(rstep), CfgW'(mode), CfgW'(fmt)};
		idx = '{REG_COLS, REG_ROWS, REG_CSTEP, REG_RSTEP, REG_MODE, REG_FMT};
		for (int i = 0; i < 6; i++) begin
			cfg_we <= 1'b1;
			cfg_index <= idx[i];
			cfg_data <= vals[i];
			@(negedge clk);
		end
		cfg_we <= 1'b0;
		{sh_cols, sh_rows, sh_cstep, sh_rstep, sh_mode, sh_fmt} =
			{cols, rows, cstep, rstep, mode, fmt};
		calm = ($urandom_range(0, 3) == 0);
	endtask

	// load every entry the current image can reach that holds nothing yet
	task automatic fill_image();
		int nc, nr;
		nc = clip_size(sh_cols, StoreCols);
		nr = clip_size(sh_rows, StoreRows);
		for (int r = 0; r < nr; r++)
			for (int c = 0; c < nc; c++)
				if (!src_loaded[r*StoreCols + c])
					push(KIND_LOAD, CoordW'(c), CoordW'(r), PixW'($urandom), 1'b0, '0, 1'b0);
	endtask

	task automatic random_traffic(int count);
		int nc, nr, cspan, rspan, sel;
		nc = clip_size(sh_cols, StoreCols);
		nr = clip_size(sh_rows, StoreRows);
		cspan = (sh_cstep == 0) ? 4095 : (((nc + 2) << 16) / int'(sh_cstep));
		rspan = (sh_rstep == 0) ? 4095 : (((nr + 2) << 16) / int'(sh_rstep));
		if (cspan > 4095)
			cspan = 4095;
		if (rspan > 4095)
			rspan = 4095;
		for (int i = 0; i < count; i++) begin
			sel = $urandom_range(0, 99);
			if (sel < 25)
				push(KIND_LOAD, CoordW'($urandom_range(0, nc - 1)),
					CoordW'($urandom_range(0, nr - 1)), PixW'($urandom), 1'b0, '0, 1'b0);
			else if (sel < 32)
				push(KIND_LOAD, CoordW'($urandom_range(StoreCols, 4095)),
					CoordW'($urandom_range(0, 4095)), PixW'($urandom), 1'b0, '0, 1'b0);
			else if (sel < 35)
				push(KIND_LOAD, CoordW'($urandom_range(0, 4095)),
					CoordW'($urandom_range(StoreRows, 4095)), PixW'($urandom), 1'b0, '0, 1'b0);
			else if (sel < 85)
				push(KIND_QUERY, CoordW'($urandom_range(0, cspan)),
					CoordW'($urandom_range(0, rspan)), PixW'($urandom), 1'b0, '0, 1'b0);
			else
				push(KIND_QUERY, CoordW'($urandom_range(0, 4095)),
					CoordW'($urandom_range(0, 4095)), PixW'($urandom), 1'b0, '0, 1'b0);
		end
	endtask

	task automatic run_phase(logic [SizeW-1:0] cols, logic [SizeW-1:0] rows,
			logic [StepW-1:0] cstep, logic [StepW-1:0] rstep, logic mode, logic fmt, int count);
		configure(cols, rows, cstep, rstep, mode, fmt);
		fill_image();
		random_traffic(count);
		drain();
	endtask

	task automatic note_mismatch(string what, scaled_t e);
		mismatches++;
		if (mismatches <= 10)
			$display("%0t: %s: expected pixel %h clamped %b, got pixel %h clamped %b",
				$realtime, what, e.pixel, e.clamped, m_axis_tdata, m_axis_tuser);
	endtask

	always @(posedge clk) begin
		scaled_t e;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (pending_pixels.size() == 0) begin
				note_mismatch("unexpected transaction", '0);
			end else begin
				e = pending_pixels.pop_front();
				if (m_axis_tdata !== e.pixel || m_axis_tuser !== e.clamped)
					note_mismatch("result mismatch", e);
			end
			ready_hold = draw_gap();
		end
	end

	always @(negedge clk) begin
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
		end else if (ready_hold > 0) begin
			m_axis_tready <= 1'b0;
			ready_hold--;
		end else begin
			m_axis_tready <= 1'b1;
		end
	end

	initial begin
		calm = 1'b0;
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		s_axis_tuser = KIND_LOAD;
		cfg_we = 1'b0;
		cfg_index = REG_COLS;
		cfg_data = '0;
		{sh_cols, sh_rows, sh_cstep, sh_rstep, sh_mode, sh_fmt} =
			{9'd256, 9'd256, 21'd65536, 21'd65536, 1'b1, 1'b0};
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		configure(9'd2, 9'd2, 21'd65536, 21'd65536, 1'b1, 1'b0);
		foreach (DIR_TAB[i])
			push(DIR_TAB[i].kind, DIR_TAB[i].col, DIR_TAB[i].row, DIR_TAB[i].pix,
				DIR_TAB[i].typed, DIR_TAB[i].exp_pix, DIR_TAB[i].exp_clamped);
		drain();

		run_phase(9'd0, 9'd0, 21'd4096, 21'd1048576, 1'b1, 1'b0, 40);
		run_phase(9'd256, 9'd2, 21'd4096, 21'd32768, 1'b1, 1'b0, 100);
		run_phase(9'd2, 9'd256, 21'd1048576, 21'd4096, 1'b0, 1'b0, 100);
		run_phase(9'd300, 9'd2, 21'd98304, 21'd65536, 1'b1, 1'b1, 100);
		run_phase(9'd511, 9'd1, 21'd0, 21'h1FFFFF, 1'b1, 1'b0, 40);
		run_phase(9'd2, 9'd511, 21'h1FFFFF, 21'd0, 1'b0, 1'b1, 40);
		for (int ph = 0; ph < 12; ph++)
			run_phase($urandom_range(0, 9) == 0 ? 9'd0 : 9'($urandom_range(1, 16)),
				9'($urandom_range(1, 16)), 21'($urandom_range(4096, 1048576)),
				21'($urandom_range(4096, 1048576)), $urandom_range(0, 3) != 0,
				$urandom_range(0, 3) == 0, 15);

		if (mismatches == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end
endmodule
